[rtl/core/qta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qta_pkg: shared types and constants for the quadtree tile address block
// Beat payloads, configuration view, pipeline item and division constants.
// ----------------------------------------------------------------------------
package qta_pkg;

    localparam int MAX_DEPTH = 16;

    // floor(x / 25) for x < 2^31: (x * M25) >> 36
    localparam logic [31:0] M25       = 32'd2748779070;
    localparam int          M25_SHIFT = 36;
    // floor(x / 100) for x < 2^14: (x * M100) >> 21
    localparam logic [14:0] M100      = 15'd20972;
    localparam int          M100_SHIFT = 21;

    typedef enum logic [2:0] {
        REG_WORLD_LOW_X  = 3'd0,
        REG_WORLD_LOW_Y  = 3'd1,
        REG_WORLD_HIGH_X = 3'd2,
        REG_WORLD_HIGH_Y = 3'd3,
        REG_OVERLAP_PCT  = 3'd4,
        REG_MAX_DEPTH    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] rect_low_x;
        logic signed [31:0] rect_low_y;
        logic signed [31:0] rect_high_x;
        logic signed [31:0] rect_high_y;
    } t_in;

    typedef struct packed {
        logic        [31:0] tile_code;
        logic        [4:0]  tile_depth;
        logic               box_valid;
        logic signed [31:0] box_low_x;
        logic signed [31:0] box_low_y;
        logic signed [31:0] box_high_x;
        logic signed [31:0] box_high_y;
    } t_out;

    typedef struct packed {
        logic signed [31:0] world_low_x;
        logic signed [31:0] world_low_y;
        logic signed [31:0] world_high_x;
        logic signed [31:0] world_high_y;
        logic        [6:0]  overlap_percent;
        logic        [4:0]  max_depth;
    } t_cfg;

    // Item as it moves from level to level
    typedef struct packed {
        t_in                rect;
        logic signed [31:0] tlx;
        logic signed [31:0] tly;
        logic signed [31:0] thx;
        logic signed [31:0] thy;
        logic        [31:0] code;
        logic        [4:0]  depth;
        logic               box_valid;
        logic signed [31:0] blx;
        logic signed [31:0] bly;
        logic signed [31:0] bhx;
        logic signed [31:0] bhy;
        logic               active;
    } t_item;

endpackage

[rtl/core/qta_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qta_cfg: configuration register file
// APB-style write/read of world box, overlap percent and depth limit.
// ----------------------------------------------------------------------------
module qta_cfg import qta_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.world_low_x     <= -32'sd20000000;
            r_cfg.world_low_y     <= -32'sd20000000;
            r_cfg.world_high_x    <= 32'sd20000000;
            r_cfg.world_high_y    <= 32'sd20000000;
            r_cfg.overlap_percent <= 7'd0;
            r_cfg.max_depth       <= 5'd14;
        end else if (w_wr) begin
            case (w_idx)
                REG_WORLD_LOW_X:  r_cfg.world_low_x     <= pwdata;
                REG_WORLD_LOW_Y:  r_cfg.world_low_y     <= pwdata;
                REG_WORLD_HIGH_X: r_cfg.world_high_x    <= pwdata;
                REG_WORLD_HIGH_Y: r_cfg.world_high_y    <= pwdata;
                REG_OVERLAP_PCT:  r_cfg.overlap_percent <= pwdata[6:0];
                REG_MAX_DEPTH:    r_cfg.max_depth       <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_WORLD_LOW_X:  prdata = r_cfg.world_low_x;
            REG_WORLD_LOW_Y:  prdata = r_cfg.world_low_y;
            REG_WORLD_HIGH_X: prdata = r_cfg.world_high_x;
            REG_WORLD_HIGH_Y: prdata = r_cfg.world_high_y;
            REG_OVERLAP_PCT:  prdata = {25'd0, r_cfg.overlap_percent};
            REG_MAX_DEPTH:    prdata = {27'd0, r_cfg.max_depth};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

[rtl/core/qta_level.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qta_level: one quadtree level, seven register stages
// Split, margin (exact /100), protrusion, hold test and quadrant pick.
// ----------------------------------------------------------------------------
module qta_level import qta_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_item      i_item,
    input  logic [6:0] i_pct,
    input  logic [4:0] i_limit,
    output logic       o_valid,
    output t_item      o_item
);

    // max(0, d0..d3); all diffs fit 33 bits signed, result fits 32 unsigned
    function automatic logic [31:0] pmax(input logic signed [32:0] d0,
                                         input logic signed [32:0] d1,
                                         input logic signed [32:0] d2,
                                         input logic signed [32:0] d3);
        logic signed [32:0] m01;
        logic signed [32:0] m23;
        logic signed [32:0] m;
        m01 = (d0 > d1) ? d0 : d1;
        m23 = (d2 > d3) ? d2 : d3;
        m   = (m01 > m23) ? m01 : m23;
        pmax = m[32] ? 32'd0 : m[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647)       sat32 = 32'sh7FFFFFFF;
        else if (v < -35'sd2147483648) sat32 = 32'sh80000000;
        else                           sat32 = v[31:0];
    endfunction

    // ---------------- stage A: centre, size, magnitude
    logic signed [32:0] w_sx, w_sy, w_cxs, w_cys, w_wx, w_wy;
    logic        [32:0] w_ax, w_ay;

    logic               r_a_valid, r_a_go, r_a_nx, r_a_ny;
    t_item              r_a_item;
    logic signed [31:0] r_a_cx, r_a_cy;
    logic        [32:0] r_a_ax, r_a_ay;

    assign w_sx  = 33'(i_item.tlx) + 33'(i_item.thx);
    assign w_sy  = 33'(i_item.tly) + 33'(i_item.thy);
    assign w_cxs = w_sx + 33'(w_sx[32]);
    assign w_cys = w_sy + 33'(w_sy[32]);
    assign w_wx  = 33'(i_item.thx) - 33'(i_item.tlx);
    assign w_wy  = 33'(i_item.thy) - 33'(i_item.tly);
    assign w_ax  = w_wx[32] ? 33'(-w_wx) : 33'(w_wx);
    assign w_ay  = w_wy[32] ? 33'(-w_wy) : 33'(w_wy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item <= i_item;
            r_a_go   <= i_item.active && (i_item.depth < i_limit);
            r_a_cx   <= w_cxs[32:1];
            r_a_cy   <= w_cys[32:1];
            r_a_ax   <= w_ax;
            r_a_ay   <= w_ay;
            r_a_nx   <= w_wx[32];
            r_a_ny   <= w_wy[32];
        end
    end

    // ---------------- stage B: quotient by 100, raw protrusion diffs
    logic        [62:0] w_prx, w_pry;
    logic signed [32:0] w_rlx, w_rly, w_rhx, w_rhy;
    logic signed [32:0] w_cx33, w_cy33;

    logic               r_b_valid, r_b_go, r_b_nx, r_b_ny;
    t_item              r_b_item;
    logic signed [31:0] r_b_cx, r_b_cy;
    logic        [7:0]  r_b_axl, r_b_ayl;
    logic        [26:0] r_b_qx, r_b_qy;
    logic signed [32:0] r_b_dxh [4];
    logic signed [32:0] r_b_dxl [4];
    logic signed [32:0] r_b_dyh [4];
    logic signed [32:0] r_b_dyl [4];

    assign w_prx  = 63'(r_a_ax[32:2]) * 63'(M25);
    assign w_pry  = 63'(r_a_ay[32:2]) * 63'(M25);
    assign w_rlx  = 33'(r_a_item.rect.rect_low_x);
    assign w_rly  = 33'(r_a_item.rect.rect_low_y);
    assign w_rhx  = 33'(r_a_item.rect.rect_high_x);
    assign w_rhy  = 33'(r_a_item.rect.rect_high_y);
    assign w_cx33 = 33'(r_a_cx);
    assign w_cy33 = 33'(r_a_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_item <= r_a_item;
            r_b_go   <= r_a_go;
            r_b_nx   <= r_a_nx;
            r_b_ny   <= r_a_ny;
            r_b_cx   <= r_a_cx;
            r_b_cy   <= r_a_cy;
            r_b_axl  <= r_a_ax[7:0];
            r_b_ayl  <= r_a_ay[7:0];
            r_b_qx   <= w_prx[M25_SHIFT+26:M25_SHIFT];
            r_b_qy   <= w_pry[M25_SHIFT+26:M25_SHIFT];
            // high half in x: [cx, thx]
            r_b_dxh[0] <= w_cx33 - w_rhx;
            r_b_dxh[1] <= w_cx33 - w_rlx;
            r_b_dxh[2] <= w_rhx - 33'(r_a_item.thx);
            r_b_dxh[3] <= w_rlx - 33'(r_a_item.thx);
            // low half in x: [tlx, cx]
            r_b_dxl[0] <= 33'(r_a_item.tlx) - w_rhx;
            r_b_dxl[1] <= 33'(r_a_item.tlx) - w_rlx;
            r_b_dxl[2] <= w_rhx - w_cx33;
            r_b_dxl[3] <= w_rlx - w_cx33;
            r_b_dyh[0] <= w_cy33 - w_rhy;
            r_b_dyh[1] <= w_cy33 - w_rly;
            r_b_dyh[2] <= w_rhy - 33'(r_a_item.thy);
            r_b_dyh[3] <= w_rly - 33'(r_a_item.thy);
            r_b_dyl[0] <= 33'(r_a_item.tly) - w_rhy;
            r_b_dyl[1] <= 33'(r_a_item.tly) - w_rly;
            r_b_dyl[2] <= w_rhy - w_cy33;
            r_b_dyl[3] <= w_rly - w_cy33;
        end
    end

    // ---------------- stage C: remainder, q*pct, per-axis protrusion
    logic [7:0] w_remx, w_remy;

    logic               r_c_valid, r_c_go, r_c_nx, r_c_ny;
    t_item              r_c_item;
    logic signed [31:0] r_c_cx, r_c_cy;
    logic        [6:0]  r_c_rx, r_c_ry;
    logic        [32:0] r_c_qpx, r_c_qpy;
    logic        [31:0] r_c_pxh, r_c_pxl, r_c_pyh, r_c_pyl;

    // remainder is below 100, so 8 low bits are exact
    assign w_remx = r_b_axl - 8'(r_b_qx[7:0] * 8'd100);
    assign w_remy = r_b_ayl - 8'(r_b_qy[7:0] * 8'd100);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_item <= r_b_item;
            r_c_go   <= r_b_go;
            r_c_nx   <= r_b_nx;
            r_c_ny   <= r_b_ny;
            r_c_cx   <= r_b_cx;
            r_c_cy   <= r_b_cy;
            r_c_rx   <= w_remx[6:0];
            r_c_ry   <= w_remy[6:0];
            r_c_qpx  <= 33'(r_b_qx) * 33'(i_pct);
            r_c_qpy  <= 33'(r_b_qy) * 33'(i_pct);
            r_c_pxh  <= pmax(r_b_dxh[0], r_b_dxh[1], r_b_dxh[2], r_b_dxh[3]);
            r_c_pxl  <= pmax(r_b_dxl[0], r_b_dxl[1], r_b_dxl[2], r_b_dxl[3]);
            r_c_pyh  <= pmax(r_b_dyh[0], r_b_dyh[1], r_b_dyh[2], r_b_dyh[3]);
            r_c_pyl  <= pmax(r_b_dyl[0], r_b_dyl[1], r_b_dyl[2], r_b_dyl[3]);
        end
    end

    // ---------------- stage D: r*pct, per-quadrant protrusion
    logic               r_d_valid, r_d_go, r_d_nx, r_d_ny;
    t_item              r_d_item;
    logic signed [31:0] r_d_cx, r_d_cy;
    logic        [13:0] r_d_rpx, r_d_rpy;
    logic        [32:0] r_d_qpx, r_d_qpy;
    logic        [31:0] r_d_p [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_item <= r_c_item;
            r_d_go   <= r_c_go;
            r_d_nx   <= r_c_nx;
            r_d_ny   <= r_c_ny;
            r_d_cx   <= r_c_cx;
            r_d_cy   <= r_c_cy;
            r_d_rpx  <= 14'(r_c_rx) * 14'(i_pct);
            r_d_rpy  <= 14'(r_c_ry) * 14'(i_pct);
            r_d_qpx  <= r_c_qpx;
            r_d_qpy  <= r_c_qpy;
            // a: high x high y, b: low x high y, c: high x low y, d: low x low y
            r_d_p[0] <= (r_c_pxh > r_c_pyh) ? r_c_pxh : r_c_pyh;
            r_d_p[1] <= (r_c_pxl > r_c_pyh) ? r_c_pxl : r_c_pyh;
            r_d_p[2] <= (r_c_pxh > r_c_pyl) ? r_c_pxh : r_c_pyl;
            r_d_p[3] <= (r_c_pxl > r_c_pyl) ? r_c_pxl : r_c_pyl;
        end
    end

    // ---------------- stage E: margin magnitude
    logic [28:0] w_fx, w_fy;

    logic               r_e_valid, r_e_go, r_e_nx, r_e_ny;
    t_item              r_e_item;
    logic signed [31:0] r_e_cx, r_e_cy;
    logic        [32:0] r_e_mx, r_e_my;
    logic        [31:0] r_e_p [4];

    assign w_fx = 29'(r_d_rpx) * 29'(M100);
    assign w_fy = 29'(r_d_rpy) * 29'(M100);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_item <= r_d_item;
            r_e_go   <= r_d_go;
            r_e_nx   <= r_d_nx;
            r_e_ny   <= r_d_ny;
            r_e_cx   <= r_d_cx;
            r_e_cy   <= r_d_cy;
            r_e_mx   <= r_d_qpx + 33'(w_fx[28:M100_SHIFT]);
            r_e_my   <= r_d_qpy + 33'(w_fy[28:M100_SHIFT]);
            r_e_p    <= r_d_p;
        end
    end

    // ---------------- stage F: widened quadrant bounds
    // a reversed tile has a negative size, so its margin shrinks the box
    logic signed [34:0] w_mxs, w_mys;

    logic               r_f_valid, r_f_go;
    t_item              r_f_item;
    logic signed [31:0] r_f_cx, r_f_cy;
    logic        [31:0] r_f_p [4];
    logic signed [34:0] r_f_wlxh, r_f_whxh, r_f_wlxl, r_f_whxl;
    logic signed [34:0] r_f_wlyh, r_f_whyh, r_f_wlyl, r_f_whyl;

    assign w_mxs = r_e_nx ? -35'(r_e_mx) : 35'(r_e_mx);
    assign w_mys = r_e_ny ? -35'(r_e_my) : 35'(r_e_my);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (i_en) begin
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_item <= r_e_item;
            r_f_go   <= r_e_go;
            r_f_cx   <= r_e_cx;
            r_f_cy   <= r_e_cy;
            r_f_p    <= r_e_p;
            r_f_wlxh <= 35'(r_e_cx) - w_mxs;
            r_f_whxh <= 35'(r_e_item.thx) + w_mxs;
            r_f_wlxl <= 35'(r_e_item.tlx) - w_mxs;
            r_f_whxl <= 35'(r_e_cx) + w_mxs;
            r_f_wlyh <= 35'(r_e_cy) - w_mys;
            r_f_whyh <= 35'(r_e_item.thy) + w_mys;
            r_f_wlyl <= 35'(r_e_item.tly) - w_mys;
            r_f_whyl <= 35'(r_e_cy) + w_mys;
        end
    end

    // ---------------- stage G: hold test, pick, descend
    logic signed [34:0] w_glx, w_gly, w_ghx, w_ghy;
    logic               w_okxh, w_okxl, w_okyh, w_okyl;
    logic [3:0]         w_hold;
    logic               w_found;
    logic [1:0]         w_pick;
    logic [31:0]        w_best;
    t_item              w_next;

    assign w_glx = 35'(r_f_item.rect.rect_low_x);
    assign w_gly = 35'(r_f_item.rect.rect_low_y);
    assign w_ghx = 35'(r_f_item.rect.rect_high_x);
    assign w_ghy = 35'(r_f_item.rect.rect_high_y);

    assign w_okxh = (w_ghx >= r_f_wlxh) && (w_ghx <= r_f_whxh)
                 && (w_glx >= r_f_wlxh) && (w_glx <= r_f_whxh);
    assign w_okxl = (w_ghx >= r_f_wlxl) && (w_ghx <= r_f_whxl)
                 && (w_glx >= r_f_wlxl) && (w_glx <= r_f_whxl);
    assign w_okyh = (w_ghy >= r_f_wlyh) && (w_ghy <= r_f_whyh)
                 && (w_gly >= r_f_wlyh) && (w_gly <= r_f_whyh);
    assign w_okyl = (w_ghy >= r_f_wlyl) && (w_ghy <= r_f_whyl)
                 && (w_gly >= r_f_wlyl) && (w_gly <= r_f_whyl);
    assign w_hold = {w_okxl && w_okyl, w_okxh && w_okyl,
                     w_okxl && w_okyh, w_okxh && w_okyh};

    always_comb begin
        w_found = 1'b0;
        w_pick  = 2'd0;
        w_best  = 32'd0;
        // strict less keeps the earlier quadrant on a tie
        for (int q = 0; q < 4; q++) begin
            if (w_hold[q] && (!w_found || (r_f_p[q] < w_best))) begin
                w_found = 1'b1;
                w_pick  = 2'(q);
                w_best  = r_f_p[q];
            end
        end
    end

    always_comb begin
        w_next = r_f_item;
        if (r_f_go) begin
            if (w_found) begin
                w_next.code      = r_f_item.code
                                 | (32'(w_pick) << {r_f_item.depth, 1'b0});
                w_next.depth     = r_f_item.depth + 5'd1;
                w_next.box_valid = 1'b1;
                if (w_pick[0]) begin
                    w_next.thx = r_f_cx;
                    w_next.blx = sat32(r_f_wlxl);
                    w_next.bhx = sat32(r_f_whxl);
                end else begin
                    w_next.tlx = r_f_cx;
                    w_next.blx = sat32(r_f_wlxh);
                    w_next.bhx = sat32(r_f_whxh);
                end
                if (w_pick[1]) begin
                    w_next.thy = r_f_cy;
                    w_next.bly = sat32(r_f_wlyl);
                    w_next.bhy = sat32(r_f_whyl);
                end else begin
                    w_next.tly = r_f_cy;
                    w_next.bly = sat32(r_f_wlyh);
                    w_next.bhy = sat32(r_f_whyh);
                end
            end else begin
                w_next.active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_item <= w_next;
        end
    end

endmodule

[rtl/core/quadtree_tile_address.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadtree_tile_address: quadtree tile key of a bounding rectangle
// Sixteen chained level units descend from the configured world box.
// ----------------------------------------------------------------------------
// Pipeline: 16 levels x 7 register stages from input beat to output beat.
// Throughput: one rectangle per unstalled cycle; each level is its own slice.
// A stalled output freezes the whole pipeline and stalls the input.
// Reset (synchronous, active low) empties the pipeline and loads the default
// world box (+-20000000), 0 percent overlap and a depth limit of 14.
// ----------------------------------------------------------------------------
module quadtree_tile_address import qta_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // rectangle beats
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    // tile key beats
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       w_cfg;
    logic [4:0] w_limit;
    logic       w_en;
    t_item      w_item  [MAX_DEPTH+1];
    logic       w_valid [MAX_DEPTH+1];

    qta_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // effective depth limit: register value capped at the number of levels
    assign w_limit = (w_cfg.max_depth < 5'(MAX_DEPTH)) ? w_cfg.max_depth
                                                       : 5'(MAX_DEPTH);

    // Single pipeline enable: everything advances unless the last slice holds
    // a beat that the sink is stalling. Bubbles are not squeezed out.
    assign w_en       = !(w_valid[MAX_DEPTH] && i_out_stall);
    assign o_in_stall = !w_en;

    // Seed item: root tile, nothing descended, box fields zero
    always_comb begin
        w_valid[0]          = i_in_valid;
        w_item[0].rect      = i_in;
        w_item[0].tlx       = w_cfg.world_low_x;
        w_item[0].tly       = w_cfg.world_low_y;
        w_item[0].thx       = w_cfg.world_high_x;
        w_item[0].thy       = w_cfg.world_high_y;
        w_item[0].code      = 32'd0;
        w_item[0].depth     = 5'd0;
        w_item[0].box_valid = 1'b0;
        w_item[0].blx       = 32'sd0;
        w_item[0].bly       = 32'sd0;
        w_item[0].bhx       = 32'sd0;
        w_item[0].bhy       = 32'sd0;
        w_item[0].active    = 1'b1;
    end

    // One unit per level; a unit passes the item through untouched once the
    // search has stopped or the depth limit is reached.
    for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_level
        qta_level u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_item  (w_item[g]),
            .i_pct   (w_cfg.overlap_percent),
            .i_limit (w_limit),
            .o_valid (w_valid[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    assign o_out_valid      = w_valid[MAX_DEPTH];
    assign o_out.tile_code  = w_item[MAX_DEPTH].code;
    assign o_out.tile_depth = w_item[MAX_DEPTH].depth;
    assign o_out.box_valid  = w_item[MAX_DEPTH].box_valid;
    assign o_out.box_low_x  = w_item[MAX_DEPTH].blx;
    assign o_out.box_low_y  = w_item[MAX_DEPTH].bly;
    assign o_out.box_high_x = w_item[MAX_DEPTH].bhx;
    assign o_out.box_high_y = w_item[MAX_DEPTH].bhy;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_box_valid_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.box_valid == (o_out.tile_depth != 5'd0)))
        else $error("box_valid disagrees with tile depth");

    a_depth_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.tile_depth <= w_limit))
        else $error("tile depth beyond limit");

    a_code_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.tile_depth < 5'd16))
        |-> ((o_out.tile_code >> {o_out.tile_depth, 1'b0}) == 32'd0))
        else $error("digits set above tile depth");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("pipeline moved while output stalled");

endmodule
